FILE: sv/stalta_pkg.sv
`default_nettype none

package stalta_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 2 * SAMPLE_W - 1;
    localparam int SUM_W      = SQ_W + ADDR_W;
    localparam int THR_W      = 8;
    localparam int IDX_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;

    // split of the running sums for the ratio products
    localparam int PART_W     = 32;
    localparam int HI_W       = SUM_W - PART_W;
    localparam int KL_W       = LEN_W + 4;
    localparam int KR_W       = THR_W + LEN_W;
    localparam int PL_LO_W    = PART_W + KL_W;
    localparam int PL_HI_W    = HI_W + KL_W;
    localparam int PR_LO_W    = PART_W + KR_W;
    localparam int PR_HI_W    = HI_W + KR_W;
    localparam int CMP_W      = SUM_W + KR_W;

    localparam logic [LEN_W-1:0] SHORT_LEN_RST = LEN_W'(50);
    localparam logic [LEN_W-1:0] LONG_LEN_RST  = LEN_W'(500);
    localparam logic [THR_W-1:0] RATIO_RST     = THR_W'(24);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_LEN = 2'd0,
        CFG_LONG_LEN  = 2'd1,
        CFG_RATIO     = 2'd2
    } t_cfg_idx;

    // zero counts as one, anything above the delay line depth as the depth
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > LEN_W'(MAX_WINDOW)) begin
            r = LEN_W'(MAX_WINDOW);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/stalta_in_if.sv
`default_nettype none

interface stalta_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [stalta_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: sv/stalta_out_if.sv
`default_nettype none

interface stalta_out_if;
    logic                             valid;
    logic                             ready;
    logic                             event_res;
    logic                             window_full;
    logic [stalta_pkg::IDX_W-1:0]     sample_index;

    modport source (output valid, output event_res, output window_full,
                    output sample_index, input ready);
    modport sink   (input valid, input event_res, input window_full,
                    input sample_index, output ready);
endinterface

`default_nettype wire

FILE: sv/stalta_ram.sv
`default_nettype none

module stalta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sta_lta_event_trigger.sv
`default_nettype none

// STA/LTA event trigger. Each sample transaction yields one result transaction carrying
// the event flag, the window-full flag and the wrapping sample index. An accepted sample
// passes through states RD2, SUM, MUL and CMP before the next is taken; CMP waits while
// the output is stalled, then registers the result. The two window taps are read one after
// the other through the single read port of the squared-sample delay line, the sums are
// updated and the new square written back, the ratio products are formed from partial
// products of the sums split at bit 32, and the exact cross-multiplied compare is done.
// A new sample is accepted while a finished result still waits on the output. The delay
// line needs no clearing pass after reset: a tap is only used once the fill count shows
// it was written since the last restart. Writing either window length restarts filling;
// the user must write configuration only while the block is idle; it does not enforce this.
module sta_lta_event_trigger (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [stalta_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [stalta_pkg::CFG_DATA_W-1:0] i_cfg_data,
    stalta_in_if.sink                            i_in,
    stalta_out_if.source                         o_out
);

    import stalta_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD2,
        S_SUM,
        S_MUL,
        S_CMP
    } t_state;

    t_state r_state;

    logic [LEN_W-1:0]           r_short_len;
    logic [LEN_W-1:0]           r_long_len;
    logic [THR_W-1:0]           r_thr;
    logic [ADDR_W-1:0]          r_wp;
    logic [LEN_W-1:0]           r_fill;
    logic [SUM_W-1:0]           r_short_sum;
    logic [SUM_W-1:0]           r_long_sum;
    logic [IDX_W-1:0]           r_idx;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [SQ_W-1:0]            r_sq;
    logic [SQ_W-1:0]            r_ltap;
    logic                       r_full;
    logic                       r_lnz;
    logic [KL_W-1:0]            r_kl;
    logic [KR_W-1:0]            r_kr;
    logic [PL_LO_W-1:0]         r_pl_lo;
    logic [PL_HI_W-1:0]         r_pl_hi;
    logic [PR_LO_W-1:0]         r_pr_lo;
    logic [PR_HI_W-1:0]         r_pr_hi;
    logic                       r_out_valid;
    logic                       r_out_event;
    logic                       r_out_full;
    logic [IDX_W-1:0]           r_out_idx;

    logic [LEN_W-1:0]           len_l;
    logic [LEN_W-1:0]           len_s_c;
    logic [LEN_W-1:0]           len_s;
    logic [ADDR_W-1:0]          tap_l;
    logic [ADDR_W-1:0]          tap_s;
    logic                       in_acc;
    logic                       ram_re;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [SQ_W-1:0]            ram_rdata;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [SUM_W-1:0]           n_long_sum;
    logic [SUM_W-1:0]           n_short_sum;
    logic [LEN_W-1:0]           n_fill;
    logic [CMP_W-1:0]           left;
    logic [CMP_W-1:0]           right;
    logic                       out_free;

    always_comb begin
        len_l   = clamp_len(r_long_len);
        len_s_c = clamp_len(r_short_len);
        len_s   = (len_s_c > len_l) ? len_l : len_s_c;
    end

    // a length of the full depth wraps to the slot being written next
    assign tap_l = r_wp - len_l[ADDR_W-1:0];
    assign tap_s = r_wp - len_s[ADDR_W-1:0];

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);

    assign ram_re    = in_acc || (r_state == S_RD2);
    assign ram_raddr = (r_state == S_IDLE) ? tap_l : tap_s;
    assign ram_we    = (r_state == S_SUM);

    stalta_ram #(
        .WIDTH (SQ_W),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_sq),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign sq_full = r_sample * r_sample;

    always_comb begin
        n_long_sum  = r_long_sum + SUM_W'(r_sq);
        n_short_sum = r_short_sum + SUM_W'(r_sq);
        if (r_fill >= len_l) begin
            n_long_sum = n_long_sum - SUM_W'(r_ltap);
        end
        if (r_fill >= len_s) begin
            n_short_sum = n_short_sum - SUM_W'(ram_rdata);
        end
        n_fill = (r_fill == LEN_W'(MAX_WINDOW)) ? r_fill : r_fill + LEN_W'(1);
    end

    assign left  = (CMP_W'(r_pl_hi) << PART_W) + CMP_W'(r_pl_lo);
    assign right = (CMP_W'(r_pr_hi) << PART_W) + CMP_W'(r_pr_lo);

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_short_len <= SHORT_LEN_RST;
            r_long_len  <= LONG_LEN_RST;
            r_thr       <= RATIO_RST;
            r_wp        <= '0;
            r_fill      <= '0;
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_CMP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sample <= i_in.sample;
                        r_state  <= S_RD2;
                    end
                end
                S_RD2: begin
                    r_sq    <= sq_full[SQ_W-1:0];
                    r_ltap  <= ram_rdata;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_long_sum  <= n_long_sum;
                    r_short_sum <= n_short_sum;
                    r_fill      <= n_fill;
                    r_wp        <= r_wp + ADDR_W'(1);
                    r_full      <= (n_fill >= len_l);
                    r_lnz       <= (n_long_sum != '0);
                    r_kl        <= {len_l, 4'b0000};
                    r_kr        <= KR_W'(r_thr) * KR_W'(len_s);
                    r_state     <= S_MUL;
                end
                S_MUL: begin
                    r_pl_lo <= PL_LO_W'(r_short_sum[PART_W-1:0]) * PL_LO_W'(r_kl);
                    r_pl_hi <= PL_HI_W'(r_short_sum[SUM_W-1:PART_W]) * PL_HI_W'(r_kl);
                    r_pr_lo <= PR_LO_W'(r_long_sum[PART_W-1:0]) * PR_LO_W'(r_kr);
                    r_pr_hi <= PR_HI_W'(r_long_sum[SUM_W-1:PART_W]) * PR_HI_W'(r_kr);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (out_free) begin
                        r_out_event <= r_full && r_lnz && (left > right);
                        r_out_full  <= r_full;
                        r_out_idx   <= r_idx;
                        r_idx       <= r_idx + IDX_W'(1);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SHORT_LEN: begin
                        r_short_len <= i_cfg_data[LEN_W-1:0];
                        r_fill      <= '0;
                        r_short_sum <= '0;
                        r_long_sum  <= '0;
                    end
                    CFG_LONG_LEN: begin
                        r_long_len  <= i_cfg_data[LEN_W-1:0];
                        r_fill      <= '0;
                        r_short_sum <= '0;
                        r_long_sum  <= '0;
                    end
                    CFG_RATIO: begin
                        r_thr <= i_cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_out_event;
    assign o_out.window_full  = r_out_full;
    assign o_out.sample_index = r_out_idx;

endmodule

`default_nettype wire

FILE: sv/stalta_chk.sv
`default_nettype none

module stalta_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_out_event,
    input wire logic                          i_out_full,
    input wire logic [stalta_pkg::IDX_W-1:0]  i_out_idx
);

    import stalta_pkg::*;

    logic             r_seen;
    logic [IDX_W-1:0] r_last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen     <= 1'b1;
            r_last_idx <= i_out_idx;
        end
    end

    // a pending result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one sample at a time: the input closes right after a transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second sample taken while one is in process");

    a_event_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_out_event || i_out_full))
        else $error("event flagged before window full");

    a_idx_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && r_seen |-> i_out_idx == r_last_idx + IDX_W'(1))
        else $error("sample index skipped or repeated");

endmodule

bind sta_lta_event_trigger stalta_chk u_stalta_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_event (o_out.event_res),
    .i_out_full  (o_out.window_full),
    .i_out_idx   (o_out.sample_index)
);

`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stalta_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_SLACK  = 12;     // leave margin for the output pipe to drain
    localparam int STALL_LIMIT  = 4000;   // cycles with no transaction on either side
    localparam int LONG_HOLD    = 200;
    localparam int MAX_PRINTED  = 100;

    // index that maps to no register, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic             event_res;
        logic             window_full;
        logic [IDX_W-1:0] sample_index;
    } trig_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic [CFG_IDX_W-1:0]         reg_idx;
        logic [CFG_DATA_W-1:0]        reg_data;
        logic signed [SAMPLE_W-1:0]   smp;
        logic                         typed;   // ev/full below are hand-written
        logic                         ev;
        logic                         full;
    } stim_row_t;

    localparam int N_ROWS = 34;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // reset defaults: window far from full
        '{ROW_SAMPLE, '0, '0, 16'sd0,     1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd32767, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000,  1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, -16'sd1,    1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd1,     1'b1, 1'b0, 1'b0},
        // zero lengths act as one, lowest threshold
        '{ROW_CFG, CFG_SHORT_LEN, 11'd0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_LONG_LEN,  11'd0, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_RATIO,     11'd1, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd0,     1'b1, 1'b0, 1'b1},
        '{ROW_SAMPLE, '0, '0, 16'sh8000,  1'b1, 1'b1, 1'b1},
        '{ROW_SAMPLE, '0, '0, 16'sd32767, 1'b1, 1'b1, 1'b1},
        '{ROW_SAMPLE, '0, '0, 16'sd1,     1'b1, 1'b1, 1'b1},
        // threshold write keeps the window full, spare index does nothing
        '{ROW_CFG, CFG_RATIO,     11'd255,  '0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_SPARE,     11'h7FF,  '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd100,   1'b1, 1'b0, 1'b1},
        // oversize lengths clamp to the line depth
        '{ROW_CFG, CFG_LONG_LEN,  11'd2047, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_SHORT_LEN, 11'd2047, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd5,     1'b1, 1'b0, 1'b0},
        // short above long: both windows equal, ratio 1.0 never exceeds itself
        '{ROW_CFG, CFG_SHORT_LEN, 11'd5,  '0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_LONG_LEN,  11'd2,  '0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_RATIO,     11'd16, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd300,   1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, -16'sd300,  1'b1, 1'b0, 1'b1},
        '{ROW_SAMPLE, '0, '0, 16'sd7,     1'b1, 1'b0, 1'b1},
        // silent window fills with a zero long sum, then a jump
        '{ROW_CFG, CFG_SHORT_LEN, 11'd1,  '0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_LONG_LEN,  11'd4,  '0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, CFG_RATIO,     11'd24, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd0,     1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd0,     1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd0,     1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd0,     1'b1, 1'b0, 1'b1},
        '{ROW_SAMPLE, '0, '0, 16'sd1000,  1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'sd10,    1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, -16'sd20000, 1'b0, 1'b0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stalta_in_if  in_ch ();
    stalta_out_if out_ch ();

    sta_lta_event_trigger uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // trigger state as the block should hold it
    logic [SQ_W-1:0]   sq_line [MAX_WINDOW];
    logic [ADDR_W-1:0] line_wr_ptr;
    logic [SUM_W-1:0]  sta_sum;
    logic [SUM_W-1:0]  lta_sum;
    logic [LEN_W-1:0]  fill_cnt;
    logic [IDX_W-1:0]  next_index;
    logic [LEN_W-1:0]  cfg_short;
    logic [LEN_W-1:0]  cfg_long;
    logic [THR_W-1:0]  cfg_ratio;

    trig_result_t pending_triggers [$];

    int err_count     = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int burst_left    = 0;

    function automatic logic [LEN_W-1:0] fit_window(input logic [LEN_W-1:0] v);
        if (v == '0)
            return LEN_W'(1);
        if (v > LEN_W'(MAX_WINDOW))
            return LEN_W'(MAX_WINDOW);
        return v;
    endfunction

    function automatic trig_result_t predict_trigger(input logic signed [SAMPLE_W-1:0] smp);
        logic [SAMPLE_W:0]  mag;
        logic [SQ_W-1:0]    sq;
        logic [LEN_W-1:0]   len_l;
        logic [LEN_W-1:0]   len_s;
        logic [ADDR_W-1:0]  tap;
        logic [63:0]        sta_side;
        logic [63:0]        lta_side;
        trig_result_t       r;
        mag = smp[SAMPLE_W-1] ? (~{1'b1, smp} + 1'b1) : {1'b0, smp};
        sq = SQ_W'(mag) * SQ_W'(mag);
        len_l = fit_window(cfg_long);
        len_s = fit_window(cfg_short);
        if (len_s > len_l)
            len_s = len_l;
        // taps are read before the new square is written
        if (fill_cnt >= len_l) begin
            tap = line_wr_ptr - len_l[ADDR_W-1:0];
            lta_sum -= SUM_W'(sq_line[tap]);
        end
        if (fill_cnt >= len_s) begin
            tap = line_wr_ptr - len_s[ADDR_W-1:0];
            sta_sum -= SUM_W'(sq_line[tap]);
        end
        lta_sum += SUM_W'(sq);
        sta_sum += SUM_W'(sq);
        sq_line[line_wr_ptr] = sq;
        line_wr_ptr++;
        if (fill_cnt < LEN_W'(MAX_WINDOW))
            fill_cnt++;
        r.window_full = (fill_cnt >= len_l);
        sta_side = 64'(sta_sum) * 64'(len_l) * 64'd16;
        lta_side = 64'(lta_sum) * 64'(cfg_ratio) * 64'(len_s);
        r.event_res = r.window_full && (lta_sum != '0) && (sta_side > lta_side);
        r.sample_index = next_index;
        next_index++;
        return r;
    endfunction

    // quiet noise with occasional loud bursts, some full-range and zero samples
    function automatic logic signed [SAMPLE_W-1:0] next_seismic_sample(input int burst_max);
        logic signed [SAMPLE_W-1:0] v;
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_left == 0 && roll < 3)
            burst_left = $urandom_range(1, burst_max);
        if (burst_left != 0) begin
            burst_left--;
            v = SAMPLE_W'($urandom_range(2000, 32767));
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end else if (roll < 12) begin
            v = SAMPLE_W'($urandom);
        end else if (roll < 17) begin
            v = '0;
        end else begin
            v = SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [IDX_W-1:0] idx,
                                   input logic [IDX_W-1:0] got, input logic [IDX_W-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("ERROR %0t: %s at sample %0d: got %0h expected %0h",
                     $realtime, what, idx, got, want);
    endtask

    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        while (pending_triggers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SHORT_LEN: cfg_short = data;
            CFG_LONG_LEN:  cfg_long  = data;
            CFG_RATIO:     cfg_ratio = data[THR_W-1:0];
            default: ;
        endcase
        // a new window length starts filling over
        if (idx == CFG_SHORT_LEN || idx == CFG_LONG_LEN) begin
            fill_cnt = '0;
            sta_sum  = '0;
            lta_sum  = '0;
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic typed,
                               input logic ev, input logic full);
        trig_result_t r;
        int gap;
        in_ch.valid  <= 1'b1;
        in_ch.sample <= smp;
        do @(posedge i_clk); while (!in_ch.ready);
        r = predict_trigger(smp);
        if (typed) begin
            r.event_res   = ev;
            r.window_full = full;
        end
        pending_triggers.push_back(r);
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] s_len, input logic [CFG_DATA_W-1:0] l_len,
                             input logic [THR_W-1:0] thr, input int idle, input int stall,
                             input int items, input bit with_hold);
        int burst_max;
        burst_max = (s_len < 2) ? 2 : ((s_len > 80) ? 80 : int'(s_len));
        write_cfg(CFG_SHORT_LEN, s_len);
        write_cfg(CFG_LONG_LEN, l_len);
        write_cfg(CFG_RATIO, {(CFG_DATA_W-THR_W)'($urandom), thr});
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int k = 0; k < items; k++) begin
            if (with_hold && k == 10)
                hold_req = LONG_HOLD;
            if (k == items / 2)
                settle_idle();
            push_sample(next_seismic_sample(burst_max), 1'b0, 1'b0, 1'b0);
        end
    endtask

    // result side: check each transaction, then pick ready for the next edge
    initial begin
        trig_result_t want;
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_triggers.size() == 0) begin
                    report_mismatch("result with nothing pending", out_ch.sample_index,
                                    out_ch.sample_index, '0);
                end else begin
                    want = pending_triggers.pop_front();
                    if (out_ch.event_res !== want.event_res)
                        report_mismatch("event_res", want.sample_index,
                                        IDX_W'(out_ch.event_res), IDX_W'(want.event_res));
                    if (out_ch.window_full !== want.window_full)
                        report_mismatch("window_full", want.sample_index,
                                        IDX_W'(out_ch.window_full), IDX_W'(want.window_full));
                    if (out_ch.sample_index !== want.sample_index)
                        report_mismatch("sample_index", want.sample_index,
                                        out_ch.sample_index, want.sample_index);
                end
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.sample <= '0;

        foreach (sq_line[j])
            sq_line[j] = '0;
        line_wr_ptr = '0;
        sta_sum     = '0;
        lta_sum     = '0;
        fill_cnt    = '0;
        next_index  = '0;
        cfg_short   = SHORT_LEN_RST;
        cfg_long    = LONG_LEN_RST;
        cfg_ratio   = RATIO_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
                write_cfg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].reg_data);
            else
                push_sample(DIRECTED_ROWS[r].smp, DIRECTED_ROWS[r].typed,
                            DIRECTED_ROWS[r].ev, DIRECTED_ROWS[r].full);
        end

        run_phase(11'd3, 11'd16, 8'd24, 0, 0, 150, 1'b0);
        run_phase(11'd1, 11'd1, 8'd1, 52, 0, 100, 1'b0);
        run_phase(11'd40, 11'd1024, 8'd255, 0, 52, 1080, 1'b0);
        run_phase(11'd2000, 11'd300, THR_W'($urandom_range(1, 255)), 7, 7, 150, 1'b0);
        run_phase(11'd8, 11'd64, THR_W'($urandom_range(17, 40)), 0, 52, 100, 1'b1);

        settle_idle();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
